/* hdl/pt8_pkg.sv */
// Shared types and constants for the prescaled 8-bit timer/counter.
// Holds the port word structs, the decoded command word and the register map.
// No dependencies.
package pt8_pkg;

	// Word taken on the item channel
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] io_address;
		logic [7:0] write_data;
		logic [7:0] cycles;
	} pt8_item_t;

	// Word delivered on the result channel
	typedef struct packed {
		logic [7:0] read_data;
		logic       address_hit;
		logic       overflow_pending;
		logic       compare_a_pending;
		logic       compare_b_pending;
	} pt8_result_t;

	// Operation codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_WRITE   = 3'd2;
	localparam logic [2:0] OP_ACK_OVF = 3'd3;
	localparam logic [2:0] OP_ACK_CMA = 3'd4;
	localparam logic [2:0] OP_ACK_CMB = 3'd5;

	// Register map
	localparam logic [7:0] ADDR_CTRL_A = 8'h24;
	localparam logic [7:0] ADDR_CTRL_B = 8'h25;
	localparam logic [7:0] ADDR_COUNT  = 8'h26;
	localparam logic [7:0] ADDR_CMP_A  = 8'h27;
	localparam logic [7:0] ADDR_CMP_B  = 8'h28;
	localparam logic [7:0] ADDR_MASK   = 8'h4E;
	localparam logic [7:0] ADDR_FLAGS  = 8'h15;

	// Flag bit positions
	localparam int unsigned FLAG_OVF = 0;
	localparam int unsigned FLAG_CMA = 1;
	localparam int unsigned FLAG_CMB = 2;
	localparam int unsigned FLAG_W   = 3;

	// Waveform mode that takes compare A as TOP
	localparam logic [2:0] MODE_CTC = 3'd2;

	localparam int unsigned ACC_W = 11;

	// Clock-select codes
	localparam logic [2:0] CS_DIV1    = 3'd1;
	localparam logic [2:0] CS_DIV8    = 3'd2;
	localparam logic [2:0] CS_DIV64   = 3'd3;
	localparam logic [2:0] CS_DIV256  = 3'd4;
	localparam logic [2:0] CS_DIV1024 = 3'd5;

	typedef enum logic [2:0] {
		K_TICK,
		K_READ,
		K_WRITE,
		K_ACK,
		K_NOP
	} pt8_kind_t;

	typedef enum logic [2:0] {
		R_CTRL_A,
		R_CTRL_B,
		R_COUNT,
		R_CMP_A,
		R_CMP_B,
		R_MASK,
		R_FLAGS,
		R_NONE
	} pt8_reg_t;

	// Decoded command passed from the front end to the execution unit
	typedef struct packed {
		pt8_kind_t         kind;
		pt8_reg_t          reg_sel;
		logic [FLAG_W-1:0] ack_mask;
		logic [7:0]        data;
		logic [7:0]        cycles;
	} pt8_cmd_t;

	// Log2 of the prescaler divider for a clock-select code (0 when stopped)
	function automatic logic [3:0] prescale_shift(input logic [2:0] cs);
		logic [3:0] sh;
		unique case (cs)
			CS_DIV1:    sh = 4'd0;
			CS_DIV8:    sh = 4'd3;
			CS_DIV64:   sh = 4'd6;
			CS_DIV256:  sh = 4'd8;
			CS_DIV1024: sh = 4'd10;
			default:    sh = 4'd0;
		endcase
		return sh;
	endfunction

	// True when the clock-select code picks a divider
	function automatic logic prescale_running(input logic [2:0] cs);
		return (cs == CS_DIV1) || (cs == CS_DIV8) || (cs == CS_DIV64) ||
			(cs == CS_DIV256) || (cs == CS_DIV1024);
	endfunction

endpackage

/* hdl/pt8_front.sv */
// Front end of the timer: takes item words and decodes them into commands.
// Depends on pt8_pkg.
module pt8_front import pt8_pkg::*; #(
	parameter int unsigned CYCLES_MAX = 255
) (
	input  logic      item_valid,
	output logic      item_ready,
	input  pt8_item_t item,
	output logic      push_valid,
	input  logic      push_ready,
	output pt8_cmd_t  push_cmd
);

	// Cycle counts above the limit are taken as the limit itself.
	localparam logic [7:0] CYC_LIM = (CYCLES_MAX < 255) ? 8'(CYCLES_MAX) : 8'hFF;

	assign item_ready = push_ready;
	assign push_valid = item_valid;

	always_comb begin
		push_cmd = '0;
		push_cmd.data = item.write_data;
		push_cmd.cycles = (item.cycles > CYC_LIM) ? CYC_LIM : item.cycles;
		push_cmd.ack_mask = '0;

		unique case (item.io_address)
			ADDR_CTRL_A: push_cmd.reg_sel = R_CTRL_A;
			ADDR_CTRL_B: push_cmd.reg_sel = R_CTRL_B;
			ADDR_COUNT:  push_cmd.reg_sel = R_COUNT;
			ADDR_CMP_A:  push_cmd.reg_sel = R_CMP_A;
			ADDR_CMP_B:  push_cmd.reg_sel = R_CMP_B;
			ADDR_MASK:   push_cmd.reg_sel = R_MASK;
			ADDR_FLAGS:  push_cmd.reg_sel = R_FLAGS;
			default:     push_cmd.reg_sel = R_NONE;
		endcase

		unique case (item.operation)
			OP_TICK:  push_cmd.kind = K_TICK;
			OP_READ:  push_cmd.kind = K_READ;
			OP_WRITE: push_cmd.kind = K_WRITE;
			OP_ACK_OVF: begin
				push_cmd.kind = K_ACK;
				push_cmd.ack_mask[FLAG_OVF] = 1'b1;
			end
			OP_ACK_CMA: begin
				push_cmd.kind = K_ACK;
				push_cmd.ack_mask[FLAG_CMA] = 1'b1;
			end
			OP_ACK_CMB: begin
				push_cmd.kind = K_ACK;
				push_cmd.ack_mask[FLAG_CMB] = 1'b1;
			end
			default:  push_cmd.kind = K_NOP;
		endcase
	end

endmodule

/* hdl/pt8_queue.sv */
// Two-entry command queue between the decoder and the execution unit.
// Depends on pt8_pkg.
module pt8_queue import pt8_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  pt8_cmd_t push_cmd,
	output logic     pop_valid,
	input  logic     pop,
	output pt8_cmd_t pop_cmd
);

	localparam int unsigned DEPTH = 2;

	pt8_cmd_t   entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign push_ready = (fill_q != 2'(DEPTH));
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* hdl/pt8_back.sv */
// Execution unit of the timer: holds the registers, drains the prescaler one
// timer step per clock and drives the registered result word.
// Depends on pt8_pkg.
module pt8_back import pt8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  pt8_cmd_t    cmd,
	output logic        result_valid,
	input  logic        result_ready,
	output pt8_result_t result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_EMIT
	} state_t;

	state_t            state_q, state_d;
	logic [7:0]        ctrl_a_q, ctrl_a_d;
	logic [7:0]        ctrl_b_q, ctrl_b_d;
	logic [7:0]        count_q, count_d;
	logic [7:0]        cmp_a_q, cmp_a_d;
	logic [7:0]        cmp_b_q, cmp_b_d;
	logic [7:0]        mask_q, mask_d;
	logic [FLAG_W-1:0] flags_q, flags_d;
	logic [ACC_W-1:0]  accum_q, accum_d;
	logic [ACC_W-1:0]  steps_q, steps_d;
	logic              rsp_valid_q, rsp_valid_d;
	pt8_result_t       rsp_q, rsp_d;

	logic             slot_free;
	logic [ACC_W-1:0] sum;
	logic [3:0]       shift;
	logic [ACC_W-1:0] steps_new;
	logic [7:0]       top;
	logic             wrap;
	logic             emit;
	logic [7:0]       rd_val;
	logic             hit;

	assign slot_free    = !rsp_valid_q || result_ready;
	assign result_valid = rsp_valid_q;
	assign result       = rsp_q;

	assign shift     = prescale_shift(ctrl_b_q[2:0]);
	assign sum       = accum_q + {{(ACC_W-8){1'b0}}, cmd.cycles};
	assign steps_new = sum >> shift;
	assign top       = ({ctrl_b_q[3], ctrl_a_q[1:0]} == MODE_CTC) ? cmp_a_q : 8'hFF;
	assign wrap      = (count_q >= top);

	always_comb begin
		state_d     = state_q;
		ctrl_a_d    = ctrl_a_q;
		ctrl_b_d    = ctrl_b_q;
		count_d     = count_q;
		cmp_a_d     = cmp_a_q;
		cmp_b_d     = cmp_b_q;
		mask_d      = mask_q;
		flags_d     = flags_q;
		accum_d     = accum_q;
		steps_d     = steps_q;
		rsp_valid_d = rsp_valid_q && !result_ready;
		rsp_d       = rsp_q;
		cmd_pop     = 1'b0;
		emit        = 1'b0;
		rd_val      = 8'h00;
		hit         = (cmd.reg_sel != R_NONE);

		unique case (cmd.reg_sel)
			R_CTRL_A: rd_val = ctrl_a_q;
			R_CTRL_B: rd_val = ctrl_b_q;
			R_COUNT:  rd_val = count_q;
			R_CMP_A:  rd_val = cmp_a_q;
			R_CMP_B:  rd_val = cmp_b_q;
			R_MASK:   rd_val = mask_q;
			R_FLAGS:  rd_val = {{(8-FLAG_W){1'b0}}, flags_q};
			default:  rd_val = 8'h00;
		endcase

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && slot_free) begin
					cmd_pop = 1'b1;
					rsp_d.read_data   = 8'h00;
					rsp_d.address_hit = 1'b0;
					unique case (cmd.kind)
						K_TICK: begin
							if (prescale_running(ctrl_b_q[2:0])) begin
								accum_d = sum & ((ACC_W'(1) << shift) - ACC_W'(1));
								if (steps_new != '0) begin
									steps_d = steps_new;
									state_d = S_STEP;
								end else begin
									emit = 1'b1;
								end
							end else begin
								emit = 1'b1;
							end
						end
						K_READ: begin
							emit = 1'b1;
							rsp_d.read_data   = hit ? rd_val : 8'h00;
							rsp_d.address_hit = hit;
						end
						K_WRITE: begin
							emit = 1'b1;
							rsp_d.address_hit = hit;
							unique case (cmd.reg_sel)
								R_CTRL_A: ctrl_a_d = cmd.data;
								R_CTRL_B: ctrl_b_d = cmd.data;
								R_COUNT: begin
									count_d = cmd.data;
									accum_d = '0;
								end
								R_CMP_A:  cmp_a_d = cmd.data;
								R_CMP_B:  cmp_b_d = cmd.data;
								R_MASK:   mask_d = cmd.data;
								R_FLAGS:  flags_d = flags_q & ~cmd.data[FLAG_W-1:0];
								default:  ;
							endcase
						end
						K_ACK: begin
							emit = 1'b1;
							flags_d = flags_q & ~cmd.ack_mask;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_STEP: begin
				// One timer step: wrap past TOP, compare against the old count.
				count_d = wrap ? 8'h00 : count_q + 8'd1;
				flags_d[FLAG_OVF] = flags_q[FLAG_OVF] | wrap;
				flags_d[FLAG_CMA] = flags_q[FLAG_CMA] | (count_q == cmp_a_q);
				flags_d[FLAG_CMB] = flags_q[FLAG_CMB] | (count_q == cmp_b_q);
				steps_d = steps_q - ACC_W'(1);
				if (steps_q == ACC_W'(1)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					rsp_d.read_data   = 8'h00;
					rsp_d.address_hit = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (emit) begin
			rsp_valid_d = 1'b1;
			rsp_d.overflow_pending  = flags_d[FLAG_OVF] & mask_d[FLAG_OVF];
			rsp_d.compare_a_pending = flags_d[FLAG_CMA] & mask_d[FLAG_CMA];
			rsp_d.compare_b_pending = flags_d[FLAG_CMB] & mask_d[FLAG_CMB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ctrl_a_q    <= '0;
			ctrl_b_q    <= '0;
			count_q     <= '0;
			cmp_a_q     <= '0;
			cmp_b_q     <= '0;
			mask_q      <= '0;
			flags_q     <= '0;
			accum_q     <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q     <= state_d;
			ctrl_a_q    <= ctrl_a_d;
			ctrl_b_q    <= ctrl_b_d;
			count_q     <= count_d;
			cmp_a_q     <= cmp_a_d;
			cmp_b_q     <= cmp_b_d;
			mask_q      <= mask_d;
			flags_q     <= flags_d;
			accum_q     <= accum_d;
			steps_q     <= steps_d;
			rsp_valid_q <= rsp_valid_d;
			rsp_q       <= rsp_d;
		end
	end

endmodule

/* hdl/prescaled_8bit_timer_counter.sv */
// Top level of the prescaled 8-bit timer/counter.
// Depends on pt8_pkg, pt8_front, pt8_queue and pt8_back.
//
// This block is an 8-bit timer/counter with a clock prescaler, reached through
// byte registers at I/O addresses 0x24 to 0x28, 0x4E (interrupt mask) and 0x15
// (flags). Each item word is a prescaler tick (cycles field), a register
// read, a register write or an interrupt acknowledge, and each item yields
// exactly one result word, in order, carrying read data, an address hit bit
// and the three pending-interrupt bits (flag AND mask) as they stand after the
// item. A decoder accepts and classifies words into a two-entry command queue,
// so a new word can be taken while the execution unit is still busy; the
// execution unit owns all timer state and drives a registered result word, and
// it starts the next command only once the result register is empty or is
// being taken in that same clock.
// Reads, writes, acknowledges and ticks that complete no timer step give their
// result straight from the idle state. A tick that completes N timer steps
// goes through the step state, one step per clock, then the emit state; N is
// the prescaler accumulator plus the cycle count, shifted right by log2 of the
// selected divider, and can reach 1278 when the divider is 1 just after a
// change from a larger one. Cycle counts above CYCLES_MAX are taken as
// CYCLES_MAX. Writing the count register also clears the prescaler.
module prescaled_8bit_timer_counter import pt8_pkg::*; #(
	parameter int unsigned CYCLES_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  pt8_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output pt8_result_t result
);

	logic     push_valid;
	logic     push_ready;
	pt8_cmd_t push_cmd;
	logic     cmd_valid;
	logic     cmd_pop;
	pt8_cmd_t cmd;

	// Decoder: classifies each word and clamps its cycle count.
	pt8_front #(
		.CYCLES_MAX(CYCLES_MAX)
	) u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Queue that lets the decoder and the execution unit stall independently.
	pt8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	// Execution unit: registers, prescaler, counter and result register.
	pt8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* tb/prescaled_8bit_timer_counter_test.sv */
// Self-checking testbench for the prescaled 8-bit timer/counter.
// Depends on pt8_pkg and prescaled_8bit_timer_counter; drives item words, predicts
// every result word from its own copy of the timer registers and checks them in order.
`timescale 1ns / 100ps

module prescaled_8bit_timer_counter_test;
	import pt8_pkg::*;

	localparam int unsigned CYCLES_MAX = 255;
	// Longest correct stretch without a handshake is a 1278-step tick plus its
	// overhead and stalls; the watchdog allows several times that.
	localparam int unsigned QUIET_LIMIT = 10000;
	localparam int unsigned DRAIN_CYCLES = 1300;
	localparam int unsigned RANDOM_WORDS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pt8_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	pt8_result_t result;

	// Words still to be offered, and result words predicted but not yet seen.
	pt8_item_t item_words[$];
	pt8_result_t predicted_words[$];

	// Shadow copy of the timer registers.
	logic [7:0] shadow_ctrl_a;
	logic [7:0] shadow_ctrl_b;
	logic [7:0] shadow_count;
	logic [7:0] shadow_cmp_a;
	logic [7:0] shadow_cmp_b;
	logic [7:0] shadow_mask;
	logic [2:0] shadow_flags;
	logic [10:0] shadow_prescale;

	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned feed_wait = 0;
	int unsigned sink_wait = 0;
	int unsigned quiet_cycles = 0;
	int unsigned timer_steps = 0;
	int unsigned overflows = 0;
	int unsigned n_tick = 0;
	int unsigned n_read = 0;
	int unsigned n_write = 0;
	int unsigned n_ack = 0;
	int unsigned n_other = 0;

	prescaled_8bit_timer_counter #(
		.CYCLES_MAX(CYCLES_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #1 clk = ~clk;

	// Applies one word to the shadow registers and returns the result word the
	// block should give for it. Pending bits are taken after the word has acted.
	function automatic pt8_result_t timer_apply(input pt8_item_t w);
		pt8_result_t r;
		int unsigned divider;
		int unsigned acc;
		int unsigned top;
		int unsigned cyc;
		logic [7:0] prior;
		r = '0;
		case (w.operation)
			OP_TICK: begin
				case (shadow_ctrl_b[2:0])
					CS_DIV1:    divider = 1;
					CS_DIV8:    divider = 8;
					CS_DIV64:   divider = 64;
					CS_DIV256:  divider = 256;
					CS_DIV1024: divider = 1024;
					default:    divider = 0;
				endcase
				// A stopped prescaler leaves everything untouched.
				if (divider != 0) begin
					cyc = (w.cycles > CYCLES_MAX) ? CYCLES_MAX : w.cycles;
					acc = shadow_prescale + cyc;
					if ({shadow_ctrl_b[3], shadow_ctrl_a[1:0]} == MODE_CTC)
						top = shadow_cmp_a;
					else
						top = 8'hFF;
					while (acc >= divider) begin
						prior = shadow_count;
						acc = acc - divider;
						timer_steps++;
						// A count already above TOP also wraps on the next step.
						if (shadow_count + 32'd1 > top) begin
							shadow_count = 8'h00;
							shadow_flags[FLAG_OVF] = 1'b1;
							overflows++;
						end else begin
							shadow_count = shadow_count + 8'd1;
						end
						if (prior == shadow_cmp_a)
							shadow_flags[FLAG_CMA] = 1'b1;
						if (prior == shadow_cmp_b)
							shadow_flags[FLAG_CMB] = 1'b1;
					end
					shadow_prescale = 11'(acc);
				end
			end
			OP_READ: begin
				r.address_hit = 1'b1;
				case (w.io_address)
					ADDR_CTRL_A: r.read_data = shadow_ctrl_a;
					ADDR_CTRL_B: r.read_data = shadow_ctrl_b;
					ADDR_COUNT:  r.read_data = shadow_count;
					ADDR_CMP_A:  r.read_data = shadow_cmp_a;
					ADDR_CMP_B:  r.read_data = shadow_cmp_b;
					ADDR_MASK:   r.read_data = shadow_mask;
					ADDR_FLAGS:  r.read_data = {5'd0, shadow_flags};
					default:     r.address_hit = 1'b0;
				endcase
			end
			OP_WRITE: begin
				r.address_hit = 1'b1;
				case (w.io_address)
					ADDR_CTRL_A: shadow_ctrl_a = w.write_data;
					ADDR_CTRL_B: shadow_ctrl_b = w.write_data;
					ADDR_COUNT: begin
						// Loading the count also restarts the prescaler.
						shadow_count = w.write_data;
						shadow_prescale = '0;
					end
					ADDR_CMP_A:  shadow_cmp_a = w.write_data;
					ADDR_CMP_B:  shadow_cmp_b = w.write_data;
					ADDR_MASK:   shadow_mask = w.write_data;
					// Writing a one to a flag bit clears that flag.
					ADDR_FLAGS:  shadow_flags = shadow_flags & ~w.write_data[2:0];
					default:     r.address_hit = 1'b0;
				endcase
			end
			OP_ACK_OVF: shadow_flags[FLAG_OVF] = 1'b0;
			OP_ACK_CMA: shadow_flags[FLAG_CMA] = 1'b0;
			OP_ACK_CMB: shadow_flags[FLAG_CMB] = 1'b0;
			default: ;
		endcase
		r.overflow_pending = shadow_flags[FLAG_OVF] & shadow_mask[FLAG_OVF];
		r.compare_a_pending = shadow_flags[FLAG_CMA] & shadow_mask[FLAG_CMA];
		r.compare_b_pending = shadow_flags[FLAG_CMB] & shadow_mask[FLAG_CMB];
		return r;
	endfunction

	// Driver. A word is offered after its drawn gap and held until taken; the
	// prediction is made when the block accepts the word. Every fourth run of
	// fifty words goes out without gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			feed_wait = 0;
			shadow_ctrl_a = '0;
			shadow_ctrl_b = '0;
			shadow_count = '0;
			shadow_cmp_a = '0;
			shadow_cmp_b = '0;
			shadow_mask = '0;
			shadow_flags = '0;
			shadow_prescale = '0;
		end else begin
			if (item_valid && item_ready) begin
				predicted_words.push_back(timer_apply(item));
				words_sent++;
			end
			if (item_valid && !item_ready) begin
				// The word stays on the bus unchanged until it is taken.
			end else if (feed_wait != 0) begin
				item_valid <= 1'b0;
				feed_wait--;
			end else if (item_words.size() != 0) begin
				item <= item_words.pop_front();
				item_valid <= 1'b1;
				feed_wait = ((words_sent / 50) % 4 == 0) ? 0 : $urandom_range(0, 5);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor. Each result word is checked against the oldest prediction, and
	// ready then drops for a drawn number of cycles; one run of fifty in three
	// is taken without stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (result_valid && result_ready) begin
				words_checked++;
				if (predicted_words.size() == 0) begin
					$error("result word %0d arrived with no prediction waiting", words_checked);
					mismatches++;
				end else begin
					automatic pt8_result_t want = predicted_words.pop_front();
					if (result.read_data !== want.read_data) begin
						$error("read_data: expected %02h, got %02h",
							want.read_data, result.read_data);
						mismatches++;
					end
					if (result.address_hit !== want.address_hit) begin
						$error("address_hit: expected %0b, got %0b",
							want.address_hit, result.address_hit);
						mismatches++;
					end
					if (result.overflow_pending !== want.overflow_pending) begin
						$error("overflow_pending: expected %0b, got %0b",
							want.overflow_pending, result.overflow_pending);
						mismatches++;
					end
					if (result.compare_a_pending !== want.compare_a_pending) begin
						$error("compare_a_pending: expected %0b, got %0b",
							want.compare_a_pending, result.compare_a_pending);
						mismatches++;
					end
					if (result.compare_b_pending !== want.compare_b_pending) begin
						$error("compare_b_pending: expected %0b, got %0b",
							want.compare_b_pending, result.compare_b_pending);
						mismatches++;
					end
				end
				sink_wait = ((words_checked / 50) % 3 == 0) ? 0 : $urandom_range(0, 5);
			end
			if (sink_wait != 0) begin
				result_ready <= 1'b0;
				sink_wait--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Counts clocks in which neither channel moves a word.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Timed out with %0d words unsent and %0d results outstanding.",
			item_words.size(), predicted_words.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic queue_word(input logic [2:0] op, input logic [7:0] addr,
			input logic [7:0] data, input logic [7:0] cyc);
		pt8_item_t w;
		w.operation = op;
		w.io_address = addr;
		w.write_data = data;
		w.cycles = cyc;
		item_words.push_back(w);
		case (op)
			OP_TICK: n_tick++;
			OP_READ: n_read++;
			OP_WRITE: n_write++;
			OP_ACK_OVF, OP_ACK_CMA, OP_ACK_CMB: n_ack++;
			default: n_other++;
		endcase
	endtask

	function automatic logic [7:0] timer_register(input int unsigned sel);
		case (sel)
			0: return ADDR_CTRL_A;
			1: return ADDR_CTRL_B;
			2: return ADDR_COUNT;
			3: return ADDR_CMP_A;
			4: return ADDR_CMP_B;
			5: return ADDR_MASK;
			default: return ADDR_FLAGS;
		endcase
	endfunction

	initial begin
		int unsigned pick;
		logic [7:0] addr;
		logic [7:0] data;
		logic [7:0] cyc;
		logic [2:0] cs;

		// Directed opening: stopped clock, full-size ticks, wrap past 0xFF and
		// past a CTC TOP, flag clearing by write and by acknowledge, the count
		// write that restarts the prescaler, a long drain after a switch from
		// the largest divider to the smallest, unknown addresses and operations.
		queue_word(OP_READ, ADDR_COUNT, 8'h00, 8'h00);
		queue_word(OP_WRITE, ADDR_MASK, 8'hFF, 8'h00);
		queue_word(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
		queue_word(OP_WRITE, ADDR_CTRL_B, {5'd0, CS_DIV1}, 8'h00);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'hFF);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'h01);
		queue_word(OP_READ, ADDR_FLAGS, 8'h00, 8'h00);
		queue_word(OP_WRITE, ADDR_FLAGS, 8'h01, 8'h00);
		queue_word(OP_ACK_CMA, 8'h00, 8'h00, 8'h00);
		queue_word(OP_ACK_CMB, 8'h00, 8'h00, 8'h00);
		queue_word(OP_WRITE, ADDR_CTRL_A, 8'h02, 8'h00);
		queue_word(OP_WRITE, ADDR_CMP_A, 8'h10, 8'h00);
		queue_word(OP_WRITE, ADDR_COUNT, 8'h80, 8'h00);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'h01);
		queue_word(OP_ACK_OVF, 8'h00, 8'h00, 8'h00);
		queue_word(OP_WRITE, ADDR_CTRL_B, {5'd0, CS_DIV1024}, 8'h00);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'hFF);
		queue_word(OP_WRITE, ADDR_COUNT, 8'h05, 8'h00);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'hFF);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'hFF);
		queue_word(OP_WRITE, ADDR_CTRL_B, {5'd1, CS_DIV1}, 8'h00);
		queue_word(OP_TICK, 8'h00, 8'h00, 8'h00);
		queue_word(OP_WRITE, 8'h00, 8'hAB, 8'h00);
		queue_word(OP_READ, 8'hFF, 8'hFF, 8'hFF);
		queue_word(3'd6, 8'hFF, 8'hFF, 8'hFF);
		queue_word(3'd7, 8'h00, 8'h00, 8'h00);

		// Random part: mostly ticks and register traffic that keeps the
		// prescaler running, with some unknown addresses and operations.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			pick = $urandom_range(0, 99);
			addr = $urandom_range(0, 255);
			data = $urandom_range(0, 255);
			cyc = $urandom_range(0, 255);
			if (pick < 40) begin
				if ($urandom_range(0, 3) == 0)
					cyc = $urandom_range(0, 7);
				queue_word(OP_TICK, addr, data, cyc);
			end else if (pick < 58) begin
				if ($urandom_range(0, 99) < 85)
					addr = timer_register($urandom_range(0, 6));
				queue_word(OP_READ, addr, data, cyc);
			end else if (pick < 85) begin
				if ($urandom_range(0, 99) < 90)
					addr = timer_register($urandom_range(0, 6));
				if (addr == ADDR_CTRL_B && $urandom_range(0, 3) != 0) begin
					// Running divider, small ones favoured so the count moves.
					case ($urandom_range(0, 9))
						0, 1, 2, 3: cs = CS_DIV1;
						4, 5, 6:    cs = CS_DIV8;
						7:          cs = CS_DIV64;
						8:          cs = CS_DIV256;
						default:    cs = CS_DIV1024;
					endcase
					data[2:0] = cs;
				end else if (addr == ADDR_CMP_A && $urandom_range(0, 1) == 0) begin
					data = $urandom_range(0, 31);
				end
				queue_word(OP_WRITE, addr, data, cyc);
			end else if (pick < 97) begin
				queue_word(OP_ACK_OVF + 3'($urandom_range(0, 2)), addr, data, cyc);
			end else begin
				queue_word(3'd6 + 3'($urandom_range(0, 1)), addr, data, cyc);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every queued word has come back as a checked result.
		while (item_words.size() != 0 || item_valid || predicted_words.size() != 0 ||
				words_checked < n_tick + n_read + n_write + n_ack + n_other)
			@(posedge clk);
		// Any late or stray result word would show up within this window.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words (%0d ticks, %0d reads, %0d writes, %0d acks, %0d other),",
			words_sent, n_tick, n_read, n_write, n_ack, n_other);
		$display("checked %0d results; %0d timer steps and %0d overflows predicted.",
			words_checked, timer_steps, overflows);
		if (mismatches == 0 && predicted_words.size() == 0 && words_checked == words_sent)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
